/* rtl/adjm_pkg.sv */
// ----------------------------------------------------------------------------
// adjm_pkg
// Types and codes shared by the adjacency matrix graph store.
// ----------------------------------------------------------------------------
`default_nettype none

package adjm_pkg;

   localparam int ROW_W = 64;   // bits in one matrix row
   localparam int VTX_W = 6;    // vertex index width
   localparam int CNT_W = 7;    // vertex count / degree width

   // request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DEGREE = 2'd1;
   localparam logic [1:0] REQ_SUCC   = 2'd2;
   localparam logic [1:0] REQ_PRED   = 2'd3;

   // response status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   // configuration register indexes
   localparam logic CSR_DIRECTED = 1'b0;
   localparam logic CSR_VCOUNT   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_A,
      ST_INS_B,
      ST_LOAD_A,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

/* rtl/adjacency_matrix_graph_store.sv */
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Bit matrix of graph edges with insert, degree and neighbor list requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_type, req_vertex_a, req_vertex_b
//  rsp     | out       | rsp_valid/stall   | status, neighbor, degrees, last
//  csr     | in        | csr_write         | csr_index, csr_wdata
//
//  Insert sets row a (and row b when undirected) before queuing its response.
//  Degree and list requests read row a, then walk rows 0..n-1 through the
//  single read port of the row memory, one row per cycle unless held:
//  a full output register holds the walk until the result is taken.
//  No clearing pass: per-row valid bits make the matrix empty at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_graph_store #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_type,
   input  wire logic [adjm_pkg::VTX_W-1:0]   req_vertex_a,
   input  wire logic [adjm_pkg::VTX_W-1:0]   req_vertex_b,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [adjm_pkg::VTX_W-1:0]        rsp_neighbor,
   output logic [adjm_pkg::CNT_W-1:0]        rsp_out_degree,
   output logic [adjm_pkg::CNT_W-1:0]        rsp_in_degree,
   output logic                              rsp_last,

   input  wire logic                         csr_write,
   input  wire logic                         csr_index,
   input  wire logic [adjm_pkg::CNT_W-1:0]   csr_wdata
);

   localparam int ROW_W = adjm_pkg::ROW_W;
   localparam int VTX_W = adjm_pkg::VTX_W;
   localparam int CNT_W = adjm_pkg::CNT_W;
   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

   // configuration
   logic             directed_ff;
   logic [CNT_W-1:0] vcount_ff;

   // sequencer and request registers
   adjm_pkg::state_type state_ff, state_in;
   logic [1:0]       type_ff;
   logic [VTX_W-1:0] a_ff;
   logic [VTX_W-1:0] b_ff;
   logic [1:0]       status_ff;

   // walk datapath
   logic [ROW_W-1:0] row_a_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] out_cnt_ff;
   logic [CNT_W-1:0] in_cnt_ff;
   logic             pend_ff;
   logic [VTX_W-1:0] prev_ff;

   // row memory
   logic [ROW_W-1:0]        edge_mem_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [ROW_W-1:0]        rd_data_ff;
   logic                    rd_vld_ff;

   // output register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [VTX_W-1:0] rsp_neighbor_ff;
   logic [CNT_W-1:0] rsp_out_ff;
   logic [CNT_W-1:0] rsp_in_ff;
   logic             rsp_last_ff;

   // combinational
   logic             req_take;
   logic [CNT_W-1:0] n_active;
   logic             req_range_err;
   logic [ROW_W-1:0] row_cur;
   logic             hit_succ;
   logic             hit_pred;
   logic             hit;
   logic             walk_done;
   logic             is_list;
   logic             out_free;
   logic [CNT_W-1:0] idx_next;

   logic             push;
   logic [1:0]       push_status;
   logic [VTX_W-1:0] push_neighbor;
   logic [CNT_W-1:0] push_out;
   logic [CNT_W-1:0] push_in;
   logic             push_last;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ROW_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic             advance;

   assign req_stall = (state_ff != adjm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      n_active = (vcount_ff > MAXV) ? MAXV : vcount_ff;
      req_range_err = ({1'b0, req_vertex_a} >= n_active) ||
                      ((req_type == adjm_pkg::REQ_INSERT) &&
                       ({1'b0, req_vertex_b} >= n_active));
      row_cur   = rd_vld_ff ? rd_data_ff : '0;
      hit_succ  = row_a_ff[idx_ff[VTX_W-1:0]];
      hit_pred  = row_cur[a_ff];
      is_list   = (type_ff == adjm_pkg::REQ_SUCC) || (type_ff == adjm_pkg::REQ_PRED);
      hit       = (type_ff == adjm_pkg::REQ_PRED) ? hit_pred : hit_succ;
      walk_done = (idx_ff == n_active);
      idx_next  = idx_ff + CNT_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adjm_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_range_err)
                  state_in = adjm_pkg::ST_RESP;
               else if (req_type == adjm_pkg::REQ_INSERT)
                  state_in = adjm_pkg::ST_INS_A;
               else
                  state_in = adjm_pkg::ST_LOAD_A;
            end
         end
         adjm_pkg::ST_INS_A: begin
            state_in = directed_ff ? adjm_pkg::ST_RESP : adjm_pkg::ST_INS_B;
         end
         adjm_pkg::ST_INS_B:  state_in = adjm_pkg::ST_RESP;
         adjm_pkg::ST_LOAD_A: state_in = adjm_pkg::ST_WALK;
         adjm_pkg::ST_WALK: begin
            if (walk_done && out_free)
               state_in = adjm_pkg::ST_IDLE;
         end
         adjm_pkg::ST_RESP: begin
            if (out_free)
               state_in = adjm_pkg::ST_IDLE;
         end
         default: state_in = adjm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      push          = 1'b0;
      push_status   = adjm_pkg::STATUS_OK;
      push_neighbor = '0;
      push_out      = '0;
      push_in       = '0;
      push_last     = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = a_ff[AW-1:0];
      wr_data       = row_cur;
      rd_addr       = '0;
      advance       = 1'b0;
      case (state_ff)
         adjm_pkg::ST_IDLE: begin
            rd_addr = req_vertex_a[AW-1:0];
         end
         adjm_pkg::ST_INS_A: begin
            wr_en   = 1'b1;
            wr_addr = a_ff[AW-1:0];
            wr_data = row_cur | (ROW_W'(1) << b_ff);
            rd_addr = b_ff[AW-1:0];
         end
         adjm_pkg::ST_INS_B: begin
            wr_en   = 1'b1;
            wr_addr = b_ff[AW-1:0];
            wr_data = row_cur | (ROW_W'(1) << a_ff);
         end
         adjm_pkg::ST_LOAD_A: begin
            rd_addr = '0;
         end
         adjm_pkg::ST_WALK: begin
            if (walk_done) begin
               push = out_free;
               if (!is_list) begin
                  push_out = out_cnt_ff;
                  push_in  = in_cnt_ff;
               end else if (pend_ff) begin
                  push_neighbor = prev_ff;
               end else begin
                  push_status = adjm_pkg::STATUS_NONE;
               end
               rd_addr = idx_ff[AW-1:0];
            end else begin
               // a new hit flushes the previous one, which is then not the last
               if (is_list && hit && pend_ff) begin
                  push          = out_free;
                  push_neighbor = prev_ff;
                  push_last     = 1'b0;
                  advance       = out_free;
               end else begin
                  advance = 1'b1;
               end
               rd_addr = advance ? idx_next[AW-1:0] : idx_ff[AW-1:0];
            end
         end
         adjm_pkg::ST_RESP: begin
            push        = out_free;
            push_status = status_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adjm_pkg::ST_IDLE;
         directed_ff  <= 1'b0;
         vcount_ff    <= CNT_W'(64);
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               adjm_pkg::CSR_DIRECTED: directed_ff <= csr_wdata[0];
               adjm_pkg::CSR_VCOUNT:   vcount_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (wr_en)
            row_valid_ff[wr_addr] <= 1'b1;
         if (push)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         edge_mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= edge_mem_ff[rd_addr];
      rd_vld_ff  <= row_valid_ff[rd_addr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff   <= req_type;
         a_ff      <= req_vertex_a;
         b_ff      <= req_vertex_b;
         status_ff <= req_range_err ? adjm_pkg::STATUS_RANGE : adjm_pkg::STATUS_OK;
      end
      if (state_ff == adjm_pkg::ST_LOAD_A) begin
         row_a_ff   <= row_cur;
         idx_ff     <= '0;
         out_cnt_ff <= '0;
         in_cnt_ff  <= '0;
         pend_ff    <= 1'b0;
      end else if (state_ff == adjm_pkg::ST_WALK && !walk_done && advance) begin
         idx_ff     <= idx_next;
         out_cnt_ff <= out_cnt_ff + CNT_W'(hit_succ);
         in_cnt_ff  <= in_cnt_ff + CNT_W'(hit_pred);
         if (hit) begin
            pend_ff <= 1'b1;
            prev_ff <= idx_ff[VTX_W-1:0];
         end
      end
      if (push) begin
         rsp_status_ff   <= push_status;
         rsp_neighbor_ff <= push_neighbor;
         rsp_out_ff      <= push_out;
         rsp_in_ff       <= push_in;
         rsp_last_ff     <= push_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_neighbor   = rsp_neighbor_ff;
   assign rsp_out_degree = rsp_out_ff;
   assign rsp_in_degree  = rsp_in_ff;
   assign rsp_last       = rsp_last_ff;

   // ------------------------------------------------------------------------
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response pushed over a pending transaction");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == adjm_pkg::ST_INS_A || state_ff == adjm_pkg::ST_INS_B))
      else $error("matrix written outside an insert");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adjm_pkg::ST_WALK) |-> (idx_ff <= n_active))
      else $error("row walk ran past the vertex limit");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != adjm_pkg::ST_IDLE))
      else $error("sequencer idle right after taking a request");

endmodule

`default_nettype wire
